[hw/rtl/ttrr_pkg.sv]
// Shared types and constants for the task table round-robin scheduler.
// Used by ttrr_ctrl, ttrr_dpath and task_table_round_robin_scheduler.
package ttrr_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_DESTROY = 3'd1,
        FN_TICK    = 3'd2,
        FN_LAUNCH  = 3'd3,
        FN_MARK    = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        SS_UNUSED  = 2'd0,
        SS_READY   = 2'd1,
        SS_RUNNING = 2'd2
    } t_sst;

    typedef enum logic [1:0] {
        RS_DONE    = 2'd0,
        RS_FULL    = 2'd1,
        RS_NORES   = 2'd2,
        RS_REFUSED = 2'd3
    } t_res;

    typedef struct packed {
        logic ctx;
        t_sst sst;
    } t_slot;

    localparam t_slot SLOT_FREE   = '{ctx: 1'b0, sst: SS_UNUSED};
    localparam t_slot SLOT0_RESET = '{ctx: 1'b0, sst: SS_RUNNING};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic start;
        logic fetch;
        logic step;
        logic exec;
        logic read;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_need;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/task_table_round_robin_scheduler.sv]
// Top level of the task table round-robin scheduler: controller plus datapath.
// Depends on ttrr_pkg, ttrr_ctrl and ttrr_dpath.
//
//   channel | direction | handshake            | fields
//   --------+-----------+----------------------+---------------------------------------------
//   in      | into      | i_valid / o_stall    | i_func, i_slot, i_resources_ok
//   out     | out of    | o_valid / i_stall    | o_status, o_new_slot, o_new_pid, o_switched,
//           |           |                      | o_current_slot, o_current_pid, o_live_count
//
// One item at a time. Destroy, launch, mark and unknown codes pass through fetch, exec,
// id read and result load. Create and tick add a slot-by-slot scan of the status table
// between fetch and exec, one slot per cycle, covering up to SLOTS-1 slots.
// Reset is synchronous and ready at once (slot 0 running with id 1, next id 2).
// A stalled result holds in the output register; the next item may be accepted meanwhile.
module task_table_round_robin_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [5:0]  i_slot,
    input  logic        i_resources_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_new_slot,
    output logic [31:0] o_new_pid,
    output logic        o_switched,
    output logic [5:0]  o_current_slot,
    output logic [31:0] o_current_pid,
    output logic [6:0]  o_live_count
);

    ttrr_pkg::t_dp_cmd cmd;
    ttrr_pkg::t_dp_sts sts;

    ttrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ttrr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_resources_ok (i_resources_ok),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_new_slot     (o_new_slot),
        .o_new_pid      (o_new_pid),
        .o_switched     (o_switched),
        .o_current_slot (o_current_slot),
        .o_current_pid  (o_current_pid),
        .o_live_count   (o_live_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting an item");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_count >= 7'd1 && o_live_count <= 7'(ttrr_pkg::SLOTS)))
        else $error("live count out of range");

    a_switch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_switched) |-> (o_status == ttrr_pkg::RS_DONE))
        else $error("switch reported with failing status");

    a_new_slot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_new_slot != 6'd0) |-> (o_status == ttrr_pkg::RS_DONE && !o_switched))
        else $error("created slot reported with failing status");

endmodule

[hw/rtl/ttrr_ctrl.sv]
// Sequencer for the scheduler: accept, table fetch, slot scan, update, id read, result load.
// Depends on ttrr_pkg.
module ttrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ttrr_pkg::t_dp_sts i_sts,
    output ttrr_pkg::t_dp_cmd o_cmd
);

    ttrr_pkg::t_state r_state;
    ttrr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttrr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ttrr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ttrr_pkg::ST_FETCH;
                end
            end
            ttrr_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_sts.scan_need) begin
                    n_state = ttrr_pkg::ST_SCAN;
                end else begin
                    n_state = ttrr_pkg::ST_EXEC;
                end
            end
            ttrr_pkg::ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ttrr_pkg::ST_EXEC;
                end
            end
            ttrr_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ttrr_pkg::ST_READ;
            end
            ttrr_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ttrr_pkg::ST_LOAD;
            end
            ttrr_pkg::ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttrr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ttrr_pkg::ST_IDLE);

endmodule

[hw/rtl/ttrr_dpath.sv]
// Datapath: slot table memory, id memory, counters, scan and result register.
// Depends on ttrr_pkg; sequenced by ttrr_ctrl.
module ttrr_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttrr_pkg::t_dp_cmd i_cmd,
    output ttrr_pkg::t_dp_sts o_sts,
    input  logic [2:0]        i_func,
    input  logic [5:0]        i_slot,
    input  logic              i_resources_ok,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [5:0]        o_new_slot,
    output logic [31:0]       o_new_pid,
    output logic              o_switched,
    output logic [5:0]        o_current_slot,
    output logic [31:0]       o_current_pid,
    output logic [6:0]        o_live_count
);

    localparam int SW = ttrr_pkg::SLOT_W;
    localparam int CW = ttrr_pkg::CNT_W;

    // captured item
    ttrr_pkg::t_func r_func;
    logic [5:0]      r_slot;
    logic            r_res_ok;

    // table state
    ttrr_pkg::t_slot r_tab     [ttrr_pkg::SLOTS];
    logic            r_tab_vld [ttrr_pkg::SLOTS];
    logic            r_pid_vld [ttrr_pkg::SLOTS];
    logic [31:0]     r_pid_mem [ttrr_pkg::SLOTS];
    logic [31:0]     r_pid_ctr;
    logic [SW-1:0]   r_running;
    logic [CW-1:0]   r_used;

    // table reads: port a at scan pointer or item slot, port b at running slot
    ttrr_pkg::t_slot r_qa;
    logic            r_qa_vld;
    logic [SW-1:0]   r_qa_idx;
    ttrr_pkg::t_slot r_qb;
    logic            r_qb_vld;
    logic            r_qb_zero;

    // scan
    logic [SW-1:0]   r_idx;
    logic [CW-1:0]   r_cnt;
    logic            r_have;
    logic [SW-1:0]   r_found;

    // slot left by a tick, written back during the id read
    logic [SW-1:0]   r_old;
    logic            r_old_wr;

    // per-item result
    ttrr_pkg::t_res  r_res;
    logic [5:0]      r_new_slot;
    logic [31:0]     r_new_pid;
    logic            r_switched;

    // id read
    logic [31:0]     r_rd_data;
    logic            r_rd_vld;
    logic            r_rd_zero;

    logic            r_o_valid;
    logic [1:0]      r_o_status;
    logic [5:0]      r_o_new_slot;
    logic [31:0]     r_o_new_pid;
    logic            r_o_switched;
    logic [5:0]      r_o_current_slot;
    logic [31:0]     r_o_current_pid;
    logic [6:0]      r_o_live_count;

    logic [SW-1:0]   tgt;
    logic            in_range;
    logic            scan_fn;
    logic [SW-1:0]   rd_a;
    ttrr_pkg::t_slot qa_ent;
    ttrr_pkg::t_slot qb_ent;
    ttrr_pkg::t_sst  tgt_st;
    logic            scan_hit;
    logic            scan_last;
    logic [SW-1:0]   run_next;
    logic [SW-1:0]   idx_next;
    ttrr_pkg::t_res  n_res;
    logic [5:0]      n_new_slot;
    logic [31:0]     n_new_pid;
    logic            n_switched;
    logic            n_pid_we;
    logic [SW-1:0]   n_pid_wa;
    logic [31:0]     n_pid_wd;
    logic            n_tab_we;
    logic [SW-1:0]   n_tab_wa;
    ttrr_pkg::t_slot n_tab_wd;
    logic [31:0]     rd_pid;

    assign tgt      = SW'(r_slot);
    assign in_range = ({3'b000, r_slot} < 9'(ttrr_pkg::SLOTS));
    assign scan_fn  = (r_func == ttrr_pkg::FN_CREATE) || (r_func == ttrr_pkg::FN_TICK);
    assign rd_a     = scan_fn ? r_idx : tgt;
    assign run_next = (r_running == SW'(ttrr_pkg::SLOTS - 1)) ? '0 : r_running + 1'b1;
    assign idx_next = (r_idx == SW'(ttrr_pkg::SLOTS - 1)) ? '0 : r_idx + 1'b1;

    // unwritten table entries read as after reset: slot 0 running, others unused
    assign qa_ent = r_qa_vld ? r_qa :
                    ((r_qa_idx == '0) ? ttrr_pkg::SLOT0_RESET : ttrr_pkg::SLOT_FREE);
    assign qb_ent = r_qb_vld ? r_qb :
                    (r_qb_zero ? ttrr_pkg::SLOT0_RESET : ttrr_pkg::SLOT_FREE);
    assign tgt_st = qa_ent.sst;

    always_comb begin
        if (r_func == ttrr_pkg::FN_CREATE) begin
            scan_hit  = (qa_ent.sst == ttrr_pkg::SS_UNUSED);
            scan_last = (r_qa_idx == SW'(ttrr_pkg::SLOTS - 1));
        end else begin
            scan_hit  = (qa_ent.sst != ttrr_pkg::SS_UNUSED) && qa_ent.ctx;
            scan_last = (r_cnt == CW'(ttrr_pkg::SLOTS - 2));
        end
    end

    assign o_sts.scan_need = scan_fn;
    assign o_sts.scan_done = scan_hit || scan_last;
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    always_comb begin
        n_res      = ttrr_pkg::RS_DONE;
        n_new_slot = '0;
        n_new_pid  = '0;
        n_switched = 1'b0;
        n_pid_we   = 1'b0;
        n_pid_wa   = tgt;
        n_pid_wd   = '0;
        case (r_func)
            ttrr_pkg::FN_CREATE: begin
                if (!r_have) begin
                    n_res = ttrr_pkg::RS_FULL;
                end else if (!r_res_ok) begin
                    n_res = ttrr_pkg::RS_NORES;
                end else begin
                    n_new_slot = 6'(r_found);
                    n_new_pid  = r_pid_ctr;
                    n_pid_we   = 1'b1;
                    n_pid_wa   = r_found;
                    n_pid_wd   = r_pid_ctr;
                end
            end
            ttrr_pkg::FN_DESTROY: begin
                if (!in_range || r_slot == 6'd0) begin
                    n_res = ttrr_pkg::RS_REFUSED;
                end else begin
                    n_pid_we = 1'b1;
                end
            end
            ttrr_pkg::FN_TICK: begin
                n_switched = r_have;
            end
            ttrr_pkg::FN_LAUNCH: begin
                if (!in_range || r_slot == 6'd0 || tgt_st == ttrr_pkg::SS_UNUSED) begin
                    n_res = ttrr_pkg::RS_REFUSED;
                end
            end
            ttrr_pkg::FN_MARK: begin
                if (!in_range || tgt_st == ttrr_pkg::SS_UNUSED) begin
                    n_res = ttrr_pkg::RS_REFUSED;
                end
            end
            default: begin
                n_res = ttrr_pkg::RS_REFUSED;
            end
        endcase
    end

    // one table write a cycle; a switching tick writes the new slot at exec
    // and the slot it leaves during the id read
    always_comb begin
        n_tab_we = 1'b0;
        n_tab_wa = tgt;
        n_tab_wd = qa_ent;
        if (i_cmd.exec && n_res == ttrr_pkg::RS_DONE) begin
            case (r_func)
                ttrr_pkg::FN_CREATE: begin
                    n_tab_we = 1'b1;
                    n_tab_wa = r_found;
                    n_tab_wd = '{ctx: 1'b0, sst: ttrr_pkg::SS_READY};
                end
                ttrr_pkg::FN_DESTROY: begin
                    n_tab_we = 1'b1;
                    n_tab_wd = ttrr_pkg::SLOT_FREE;
                end
                ttrr_pkg::FN_TICK: begin
                    n_tab_we = r_have;
                    n_tab_wa = r_found;
                    n_tab_wd = '{ctx: 1'b1, sst: ttrr_pkg::SS_RUNNING};
                end
                ttrr_pkg::FN_LAUNCH: begin
                    n_tab_we     = 1'b1;
                    n_tab_wd.sst = ttrr_pkg::SS_RUNNING;
                end
                ttrr_pkg::FN_MARK: begin
                    n_tab_we     = 1'b1;
                    n_tab_wd.ctx = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.read && r_old_wr) begin
            n_tab_we = 1'b1;
            n_tab_wa = r_old;
            n_tab_wd = '{ctx: 1'b1, sst: ttrr_pkg::SS_READY};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ttrr_pkg::SLOTS; i++) begin
                r_tab_vld[i] <= 1'b0;
                r_pid_vld[i] <= 1'b0;
            end
            r_pid_ctr <= 32'd2;
            r_running <= '0;
            r_used    <= CW'(1);
            r_func    <= ttrr_pkg::FN_TICK;
            r_have    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_func <= ttrr_pkg::t_func'(i_func);
                r_have <= 1'b0;
            end
            if (i_cmd.step && scan_hit) begin
                r_have <= 1'b1;
            end
            if (i_cmd.exec && n_res == ttrr_pkg::RS_DONE) begin
                case (r_func)
                    ttrr_pkg::FN_CREATE: begin
                        r_pid_ctr <= r_pid_ctr + 32'd1;
                        r_used    <= r_used + 1'b1;
                    end
                    ttrr_pkg::FN_DESTROY: begin
                        if (tgt_st != ttrr_pkg::SS_UNUSED) begin
                            r_used <= r_used - 1'b1;
                        end
                    end
                    ttrr_pkg::FN_TICK: begin
                        if (r_have) begin
                            r_running <= r_found;
                        end
                    end
                    ttrr_pkg::FN_LAUNCH: begin
                        r_running <= tgt;
                    end
                    default: begin
                    end
                endcase
            end
            if (n_tab_we) begin
                r_tab_vld[n_tab_wa] <= 1'b1;
            end
            if (i_cmd.exec && n_pid_we) begin
                r_pid_vld[n_pid_wa] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_slot   <= i_slot;
            r_res_ok <= i_resources_ok;
            r_cnt    <= '0;
            r_idx    <= (i_func == ttrr_pkg::FN_CREATE) ? SW'(1) : run_next;
        end else if (i_cmd.fetch || i_cmd.step) begin
            r_idx <= idx_next;
        end
        if (i_cmd.step) begin
            if (scan_hit) begin
                r_found <= r_qa_idx;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        r_qa      <= r_tab[rd_a];
        r_qa_vld  <= r_tab_vld[rd_a];
        r_qa_idx  <= rd_a;
        r_qb      <= r_tab[r_running];
        r_qb_vld  <= r_tab_vld[r_running];
        r_qb_zero <= (r_running == '0);
        if (n_tab_we) begin
            r_tab[n_tab_wa] <= n_tab_wd;
        end
        if (i_cmd.exec) begin
            r_res      <= n_res;
            r_new_slot <= n_new_slot;
            r_new_pid  <= n_new_pid;
            r_switched <= n_switched;
            r_old      <= r_running;
            r_old_wr   <= (r_func == ttrr_pkg::FN_TICK) && r_have &&
                          (qb_ent.sst != ttrr_pkg::SS_UNUSED);
            if (n_pid_we) begin
                r_pid_mem[n_pid_wa] <= n_pid_wd;
            end
        end
        if (i_cmd.read) begin
            r_rd_data <= r_pid_mem[r_running];
            r_rd_vld  <= r_pid_vld[r_running];
            r_rd_zero <= (r_running == '0);
        end
        if (i_cmd.load) begin
            r_o_status       <= r_res;
            r_o_new_slot     <= r_new_slot;
            r_o_new_pid      <= r_new_pid;
            r_o_switched     <= r_switched;
            r_o_current_slot <= 6'(r_running);
            r_o_current_pid  <= rd_pid;
            r_o_live_count   <= 7'(r_used);
        end
    end

    // unwritten entries hold the reset ids: 1 for slot 0, else 0
    assign rd_pid = r_rd_vld ? r_rd_data : {31'd0, r_rd_zero};

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_new_slot     = r_o_new_slot;
    assign o_new_pid      = r_o_new_pid;
    assign o_switched     = r_o_switched;
    assign o_current_slot = r_o_current_slot;
    assign o_current_pid  = r_o_current_pid;
    assign o_live_count   = r_o_live_count;

endmodule

[sim/ttrr_checker.sv]
// Scoreboard for the task table round-robin scheduler: predicts each result and compares it.
// Depends on ttrr_pkg; instantiated by tb beside the block.
module ttrr_checker
    import ttrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_func,
    input  logic [5:0]  i_slot,
    input  logic        i_resources_ok,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [5:0]  i_new_slot,
    input  logic [31:0] i_new_pid,
    input  logic        i_switched,
    input  logic [5:0]  i_current_slot,
    input  logic [31:0] i_current_pid,
    input  logic [6:0]  i_live_count,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_switches,
    output int          o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_res        status;
        logic [5:0]  new_slot;
        logic [31:0] new_pid;
        logic        switched;
        logic [5:0]  cur_slot;
        logic [31:0] cur_pid;
        logic [6:0]  live;
    } t_sched_out;

    t_sst              slot_st [SLOTS];
    logic              ctx     [SLOTS];
    logic [31:0]       slot_id [SLOTS];
    logic [31:0]       next_id;
    logic [SLOT_W-1:0] cur;
    logic [CNT_W-1:0]  live;

    t_sched_out sched_q[$];
    t_sched_out want;
    int err_cnt, pending_cnt, checked_cnt, switch_cnt, full_cnt;

    assign o_errors    = err_cnt;
    assign o_pending   = pending_cnt;
    assign o_checked   = checked_cnt;
    assign o_switches  = switch_cnt;
    assign o_full_hits = full_cnt;

    initial begin
        err_cnt = 0;
        pending_cnt = 0;
        checked_cnt = 0;
        switch_cnt = 0;
        full_cnt = 0;
    end

    function automatic t_sched_out apply_cmd(logic [2:0] fn, logic [5:0] sl, logic ok);
        t_sched_out        r;
        int                k, idx;
        logic              hit;
        logic [SLOT_W-1:0] nxt;
        logic              in_range;
        r = '0;
        r.status = RS_DONE;
        in_range = int'(sl) < SLOTS;
        hit = 1'b0;
        nxt = cur;
        case (fn)
            FN_CREATE: begin
                for (k = 1; k < SLOTS; k++) begin
                    if (!hit && slot_st[k] == SS_UNUSED) begin
                        nxt = SLOT_W'(k);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    r.status = RS_FULL;
                    full_cnt++;
                end else if (!ok) begin
                    r.status = RS_NORES;
                end else begin
                    slot_st[nxt] = SS_READY;
                    ctx[nxt] = 1'b0;
                    slot_id[nxt] = next_id;
                    r.new_slot = 6'(nxt);
                    r.new_pid = next_id;
                    next_id = next_id + 32'd1;
                    live = live + 1'b1;
                end
            end
            FN_DESTROY: begin
                if (!in_range || sl == '0) begin
                    r.status = RS_REFUSED;
                end else begin
                    if (slot_st[sl] != SS_UNUSED) live = live - 1'b1;
                    slot_st[sl] = SS_UNUSED;
                    ctx[sl] = 1'b0;
                    slot_id[sl] = '0;
                end
            end
            FN_TICK: begin
                for (k = 1; k <= SLOTS; k++) begin
                    idx = (int'(cur) + k) % SLOTS;
                    if (!hit && (slot_st[idx] == SS_READY || slot_st[idx] == SS_RUNNING)
                            && ctx[idx]) begin
                        nxt = SLOT_W'(idx);
                        hit = 1'b1;
                    end
                end
                if (nxt != cur) begin
                    if (slot_st[cur] != SS_UNUSED) begin
                        slot_st[cur] = SS_READY;
                        ctx[cur] = 1'b1;
                    end
                    slot_st[nxt] = SS_RUNNING;
                    cur = nxt;
                    r.switched = 1'b1;
                    switch_cnt++;
                end
            end
            FN_LAUNCH: begin
                if (!in_range || sl == '0 || slot_st[sl] == SS_UNUSED) begin
                    r.status = RS_REFUSED;
                end else begin
                    cur = SLOT_W'(sl);
                    slot_st[sl] = SS_RUNNING;
                end
            end
            FN_MARK: begin
                if (!in_range || slot_st[sl] == SS_UNUSED) r.status = RS_REFUSED;
                else ctx[sl] = 1'b1;
            end
            default: r.status = RS_REFUSED;
        endcase
        r.cur_slot = 6'(cur);
        r.cur_pid = slot_id[cur];
        r.live = 7'(live);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_st[k] = SS_UNUSED;
                ctx[k] = 1'b0;
                slot_id[k] = '0;
            end
            slot_st[0] = SS_RUNNING;
            slot_id[0] = 32'd1;
            next_id = 32'd2;
            cur = '0;
            live = CNT_W'(1);
            sched_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sched_q.size() == 0) begin
                    $display("%0t: result with no item outstanding, status %0d", $time,
                             i_status);
                    err_cnt++;
                end else begin
                    want = sched_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("new_slot", 32'(want.new_slot), 32'(i_new_slot));
                    check_field("new_pid", want.new_pid, i_new_pid);
                    check_field("switched", 32'(want.switched), 32'(i_switched));
                    check_field("current_slot", 32'(want.cur_slot), 32'(i_current_slot));
                    check_field("current_pid", want.cur_pid, i_current_pid);
                    check_field("live_count", 32'(want.live), 32'(i_live_count));
                    checked_cnt++;
                end
            end
            if (i_in_valid && !i_in_stall)
                sched_q.push_back(apply_cmd(i_func, i_slot, i_resources_ok));
        end
        pending_cnt = sched_q.size();
    end

endmodule

[sim/tb.sv]
// Testbench top for the task table round-robin scheduler: clock, reset, item stimulus.
// Drives directed then random items with random gaps and stalls; ttrr_checker judges results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ttrr_pkg::*;

    localparam int RAND_ITEMS = 450;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_func;
    logic [5:0]  i_slot;
    logic        i_resources_ok;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [5:0]  o_new_slot;
    logic [31:0] o_new_pid;
    logic        o_switched;
    logic [5:0]  o_current_slot;
    logic [31:0] o_current_pid;
    logic [6:0]  o_live_count;

    int chk_errors, chk_pending, chk_checked, chk_switches, chk_full;
    int n_sent = 0;
    bit rush_in = 1'b0;
    bit rush_out = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task_table_round_robin_scheduler u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_resources_ok (i_resources_ok),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_new_slot     (o_new_slot),
        .o_new_pid      (o_new_pid),
        .o_switched     (o_switched),
        .o_current_slot (o_current_slot),
        .o_current_pid  (o_current_pid),
        .o_live_count   (o_live_count)
    );

    ttrr_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_resources_ok (i_resources_ok),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_status       (o_status),
        .i_new_slot     (o_new_slot),
        .i_new_pid      (o_new_pid),
        .i_switched     (o_switched),
        .i_current_slot (o_current_slot),
        .i_current_pid  (o_current_pid),
        .i_live_count   (o_live_count),
        .o_errors       (chk_errors),
        .o_pending      (chk_pending),
        .o_checked      (chk_checked),
        .o_switches     (chk_switches),
        .o_full_hits    (chk_full)
    );

    // low slots are the ones creates fill first, so favor them
    function automatic logic [5:0] pick_slot();
        if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 15));
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    task automatic put_item(input logic [2:0] fn, input logic [5:0] sl, input logic ok);
        int gap;
        if ($urandom_range(0, 39) == 0) rush_in = ~rush_in;
        gap = rush_in ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_slot <= sl;
        i_resources_ok <= ok;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        n_sent++;
    endtask

    initial begin : result_side
        int hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rush_out = ~rush_out;
            hold = rush_out ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                i_stall <= 1'b1;
                if ($urandom_range(0, 1) != 0) begin
                    do @(posedge i_clk); while (!o_valid);
                    @(negedge i_clk);
                end
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin : item_side
        int r, k, n_start, fn_code;
        logic [2:0] fn;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FN_CREATE;
        i_slot = '0;
        i_resources_ok = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        put_item(FN_TICK, '0, 1'b0);
        put_item(FN_CREATE, '0, 1'b0);
        put_item(FN_CREATE, '0, 1'b1);
        put_item(FN_CREATE, '0, 1'b1);
        put_item(FN_DESTROY, '0, 1'b0);
        put_item(FN_LAUNCH, '0, 1'b1);
        put_item(FN_LAUNCH, 6'(SLOTS - 1), 1'b1);
        put_item(FN_MARK, 6'(SLOTS - 1), 1'b0);
        put_item(FN_MARK, 6'd1, 1'b0);
        put_item(FN_MARK, 6'd2, 1'b1);
        put_item(FN_TICK, '0, 1'b0);
        put_item(FN_TICK, 6'(SLOTS - 1), 1'b1);
        put_item(FN_TICK, '0, 1'b0);
        put_item(FN_LAUNCH, 6'd1, 1'b0);
        put_item(FN_DESTROY, 6'd1, 1'b0);
        put_item(FN_TICK, '0, 1'b0);
        put_item(FN_DESTROY, 6'(SLOTS - 1), 1'b1);
        for (fn_code = int'(FN_MARK) + 1; fn_code < 2 ** $bits(t_func); fn_code++)
            put_item(3'(fn_code), 6'(SLOTS - 1), 1'b1);
        put_item(FN_MARK, '0, 1'b1);
        put_item(FN_LAUNCH, 6'd2, 1'b1);
        put_item(FN_CREATE, 6'(SLOTS - 1), 1'b1);

        // random
        n_start = n_sent;
        while (n_sent - n_start < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (chk_full == 0 && n_sent - n_start > 150) r = 0;
            if (r < 4) begin
                // fill the table and run into it
                repeat (SLOTS + 2)
                    put_item(FN_CREATE, pick_slot(), $urandom_range(0, 9) != 0);
            end else if (r < 10) begin
                repeat (24)
                    put_item(FN_DESTROY, 6'($urandom_range(1, SLOTS - 1)),
                             1'($urandom_range(0, 1)));
            end else if (r < 35) begin
                k = $urandom_range(1, 4);
                repeat (k) put_item(FN_MARK, pick_slot(), 1'($urandom_range(0, 1)));
                k = $urandom_range(1, 4);
                repeat (k) put_item(FN_TICK, pick_slot(), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    put_item(FN_LAUNCH, pick_slot(), 1'($urandom_range(0, 1)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20) fn = FN_CREATE;
                else if (r < 32) fn = FN_DESTROY;
                else if (r < 54) fn = FN_TICK;
                else if (r < 68) fn = FN_LAUNCH;
                else if (r < 96) fn = FN_MARK;
                else fn = 3'($urandom_range(int'(FN_MARK) + 1, 2 ** $bits(t_func) - 1));
                put_item(fn, pick_slot(), $urandom_range(0, 9) != 0);
            end
        end
        i_valid <= 1'b0;

        while (chk_pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("summary: %0d items sent, %0d results compared", n_sent, chk_checked);
        $display("summary: %0d task switches, %0d creates against a full table",
                 chk_switches, chk_full);
        if (chk_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
